@@ design/ihv_pkg.sv @@
// ----------------------------------------------------------------------------
// ihv_pkg
// Shared types, constants and helpers for the hyphenated ISBN-10 validator.
// ----------------------------------------------------------------------------
package ihv_pkg;

  localparam int CHAR_W    = 8;
  localparam int LEN_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;

  localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 8'h2D;  // '-'
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CHAR_X      = 8'h58;  // 'X'

  localparam logic [3:0] MOD11       = 4'd11;
  localparam logic [3:0] X_VALUE     = 4'd10;
  localparam logic [3:0] NUM_DIGITS  = 4'd10;
  localparam logic [3:0] LAST_WEIGHT = 4'd9;   // digit count when the tenth digit arrives
  localparam logic [1:0] NUM_HYPHENS = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_THIRD = 2'd1;

  localparam logic [CFG_DAT_W-1:0] MAX_FIRST_RST = 4'd5;
  localparam logic [CFG_DAT_W-1:0] MAX_THIRD_RST = 4'd6;

  typedef struct packed {
    logic [CFG_DAT_W-1:0] max_first;
    logic [CFG_DAT_W-1:0] max_third;
  } cfg_t;

  // dsum holds the plain digit sum mod 11, wsum the sum of its prefixes mod 11;
  // after ten digits wsum equals the 10..1 weighted sum mod 11.
  typedef struct packed {
    logic [1:0]       hyphens;
    logic [LEN_W-1:0] group_len;
    logic [LEN_W-1:0] digits;
    logic [3:0]       dsum;
    logic [3:0]       wsum;
    logic             prev_hyphen;
    logic             at_start;
    logic             err;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    hyphens:     2'd0,
    group_len:   4'd0,
    digits:      4'd0,
    dsum:        4'd0,
    wsum:        4'd0,
    prev_hyphen: 1'b0,
    at_start:    1'b1,
    err:         1'b0
  };

  // a, b < 11
  function automatic logic [3:0] add_mod11(logic [3:0] a, logic [3:0] b);
    logic [4:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MOD11}) begin
      s = s - {1'b0, MOD11};
    end
    return s[3:0];
  endfunction

endpackage

@@ design/ihv_char_if.sv @@
// ----------------------------------------------------------------------------
// ihv_char_if
// Character stream channel: one character and its end-of-string mark.
// ----------------------------------------------------------------------------
interface ihv_char_if;
  logic                       valid;
  logic                       ready;
  logic [ihv_pkg::CHAR_W-1:0] char_code;
  logic                       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

@@ design/ihv_res_if.sv @@
// ----------------------------------------------------------------------------
// ihv_res_if
// Result channel: one verdict per string.
// ----------------------------------------------------------------------------
interface ihv_res_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink   (input valid, input valid_res, output ready);
endinterface

@@ design/ihv_cfg_if.sv @@
// ----------------------------------------------------------------------------
// ihv_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ihv_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ihv_pkg::CFG_IDX_W-1:0] index;
  logic [ihv_pkg::CFG_DAT_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ design/ihv_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ihv_cfg_regs
// Group length limit registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module ihv_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  ihv_cfg_if.sink          cfg_ch,
  output ihv_pkg::cfg_t    cfg_o
);

  ihv_pkg::cfg_t cfg_r;
  ihv_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg_o        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        ihv_pkg::CFG_MAX_FIRST: cfg_nxt.max_first = cfg_ch.wdata;
        ihv_pkg::CFG_MAX_THIRD: cfg_nxt.max_third = cfg_ch.wdata;
        default:                cfg_nxt = cfg_r;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_first <= ihv_pkg::MAX_FIRST_RST;
      cfg_r.max_third <= ihv_pkg::MAX_THIRD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ design/ihv_scan.sv @@
// ----------------------------------------------------------------------------
// ihv_scan
// Per-string scanner: folds one character per cycle, when step_i is high, into the string state
// and produces the verdict at the last character.
// ----------------------------------------------------------------------------
module ihv_scan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_i,
  input  logic [ihv_pkg::CHAR_W-1:0] char_i,
  input  logic                       last_i,
  input  ihv_pkg::cfg_t              cfg_i,
  output logic                       ok_o
);

  ihv_pkg::scan_state_t s_r;
  ihv_pkg::scan_state_t s_nxt;
  ihv_pkg::scan_state_t upd;

  logic       is_hyphen;
  logic       is_digit;
  logic       is_x;
  logic [3:0] dval;
  logic [3:0] dsum_new;

  assign is_hyphen = (char_i == ihv_pkg::CHAR_HYPHEN);
  assign is_digit  = (char_i inside {[ihv_pkg::CHAR_ZERO:ihv_pkg::CHAR_NINE]});
  assign is_x      = (char_i == ihv_pkg::CHAR_X);
  assign dval      = is_x ? ihv_pkg::X_VALUE : char_i[3:0];
  assign dsum_new  = ihv_pkg::add_mod11(s_r.dsum, dval);

  always_comb begin
    upd = s_r;
    if (!s_r.err) begin
      if (is_hyphen) begin
        if (s_r.at_start || s_r.prev_hyphen || s_r.hyphens == ihv_pkg::NUM_HYPHENS) begin
          upd.err = 1'b1;
        end else begin
          if (s_r.hyphens == 2'd0 && s_r.group_len > cfg_i.max_first) begin
            upd.err = 1'b1;
          end
          if (s_r.hyphens == 2'd2 && s_r.group_len > cfg_i.max_third) begin
            upd.err = 1'b1;
          end
          upd.hyphens     = s_r.hyphens + 2'd1;
          upd.group_len   = '0;
          upd.prev_hyphen = 1'b1;
        end
      end else if (is_digit || (is_x && s_r.digits == ihv_pkg::LAST_WEIGHT)) begin
        if (s_r.digits >= ihv_pkg::NUM_DIGITS) begin
          upd.err = 1'b1;
        end else begin
          upd.dsum        = dsum_new;
          upd.wsum        = ihv_pkg::add_mod11(s_r.wsum, dsum_new);
          upd.digits      = s_r.digits + 4'd1;
          upd.group_len   = s_r.group_len + 4'd1;  // bounded by the digit count
          upd.prev_hyphen = 1'b0;
        end
      end else begin
        // misplaced X or any other character
        upd.err = 1'b1;
      end
    end
    upd.at_start = 1'b0;
  end

  assign ok_o = !upd.err && upd.hyphens == ihv_pkg::NUM_HYPHENS &&
                upd.digits == ihv_pkg::NUM_DIGITS && upd.group_len == 4'd1 &&
                upd.wsum == 4'd0;

  always_comb begin
    s_nxt = s_r;
    if (step_i) begin
      s_nxt = last_i ? ihv_pkg::SCAN_RESET : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= ihv_pkg::SCAN_RESET;
    end else begin
      s_r <= s_nxt;
    end
  end

  // digit counter never runs past ten
  a_digits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    s_r.digits <= ihv_pkg::NUM_DIGITS)
    else $error("digit count above ten");

  // end of string returns the scanner to its start state
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && last_i |=> s_r.at_start && s_r.digits == 4'd0 && !s_r.err &&
                         s_r.hyphens == 2'd0)
    else $error("string state not cleared after last character");

  // a pass verdict needs a clean, complete string
  a_ok_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && last_i && ok_o |-> !s_r.err && s_r.hyphens == ihv_pkg::NUM_HYPHENS)
    else $error("pass verdict on malformed string");

  // nothing moves without a step
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step_i |=> $stable(s_r))
    else $error("scanner state changed without a character");

endmodule

@@ design/isbn10_hyphenated_validator_top.sv @@
// ----------------------------------------------------------------------------
// isbn10_hyphenated_validator_top
// Hyphenated ISBN-10 validator: character stream in, one verdict per string.
// ----------------------------------------------------------------------------
//  channel  dir  payload                     transaction
//  in_ch    in   char_code[7:0], last_char   valid & ready
//  out_ch   out  valid_res                   valid & ready
//  cfg_ch   in   index[1:0], wdata[3:0]      valid & ready (ready tied high)
//
//  One character per cycle while no verdict is stalled: input register,
//  combinational scan update, result register. A verdict is registered
//  when its last character steps the scanner out of the input register.
//  Reset (rst_n low, synchronous) clears the string state and loads group
//  limits 5 and 6. A stalled result holds only the next last-character
//  transaction; other characters keep flowing.
// ----------------------------------------------------------------------------
module isbn10_hyphenated_validator_top (
  input  logic       clk,
  input  logic       rst_n,
  ihv_char_if.sink   in_ch,
  ihv_res_if.source  out_ch,
  ihv_cfg_if.sink    cfg_ch
);

  ihv_pkg::cfg_t cfg;

  logic                       in_v_r;
  logic [ihv_pkg::CHAR_W-1:0] in_char_r;
  logic                       in_last_r;
  logic                       out_v_r;
  logic                       res_r;

  logic out_free;
  logic step;
  logic ok;

  assign out_free    = !out_v_r || out_ch.ready;
  // a last character needs room in the result register
  assign step        = in_v_r && (!in_last_r || out_free);
  assign in_ch.ready = !in_v_r || step;

  assign out_ch.valid     = out_v_r;
  assign out_ch.valid_res = res_r;

  ihv_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  ihv_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .char_i (in_char_r),
    .last_i (in_last_r),
    .cfg_i  (cfg),
    .ok_o   (ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_char_r <= in_ch.char_code;
      in_last_r <= in_ch.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step && in_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last_r) begin
      res_r <= ok;
    end
  end

  // a new verdict only comes from a consumed last character
  a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(step && in_last_r))
    else $error("result raised without a last character");

  // never overwrite a verdict that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    step && in_last_r |-> out_free)
    else $error("result overwritten while stalled");

  // held input only waits on a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !step |-> in_last_r && out_v_r && !out_ch.ready)
    else $error("input stalled without cause");

endmodule
